FILE: src/three_point_circumradius_stream_top_assert.svh
`ifndef THREE_POINT_CIRCUMRADIUS_STREAM_TOP_ASSERT_SVH
`define THREE_POINT_CIRCUMRADIUS_STREAM_TOP_ASSERT_SVH

// same-cycle implication, masked during reset
`define TPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tpc assertion failed");

// next-cycle implication, masked during reset
`define TPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tpc assertion failed");

`endif

FILE: src/tpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tpc_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int MAG_W      = COORD_BITS;
    localparam int SQ_W       = 2 * MAG_W + 1;
    localparam int PROD_W     = 3 * SQ_W;
    localparam int CROSS_W    = 2 * MAG_W + 2;
    localparam int ROOT_W     = 3 * MAG_W + 2;
    localparam int RAD_W      = 32;
    localparam int CNT_W      = $clog2(ROOT_W + 1);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    typedef struct packed {
        logic                         do_circ;
        logic                         do_zero;
        logic                         zero_end;
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // {sign, magnitude} of b - a
    function automatic logic [MAG_W:0] diff_sm(input logic signed [COORD_BITS-1:0] a,
                                               input logic signed [COORD_BITS-1:0] b);
        logic signed [DIFF_W-1:0] d;
        logic [DIFF_W-1:0]        m;
        d = DIFF_W'(b) - DIFF_W'(a);
        m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        return {d[DIFF_W-1], m[MAG_W-1:0]};
    endfunction

endpackage
`default_nettype wire

FILE: src/tpc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module tpc_front (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [tpc_pkg::COORD_BITS-1:0] s_point_x,
    input  wire logic signed [tpc_pkg::COORD_BITS-1:0] s_point_y,
    input  wire logic                                  s_first_point,
    input  wire logic                                  s_last_point,
    input  wire tpc_pkg::q_status_t                    q_status,
    output logic                                       push,
    output tpc_pkg::job_t                              push_job
);

    logic signed [tpc_pkg::COORD_BITS-1:0] older_x_reg, older_y_reg;
    logic signed [tpc_pkg::COORD_BITS-1:0] newer_x_reg, newer_y_reg;
    logic [1:0] seen_reg, seen_next;
    logic       shift_pts, load_newer;
    logic       accept;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        push_job          = '0;
        push_job.ax       = older_x_reg;
        push_job.ay       = older_y_reg;
        push_job.bx       = newer_x_reg;
        push_job.by       = newer_y_reg;
        push_job.cx       = s_point_x;
        push_job.cy       = s_point_y;
        push_job.zero_end = 1'b1;
        push              = 1'b0;
        seen_next         = seen_reg;
        shift_pts         = 1'b0;
        load_newer        = 1'b0;
        if (accept) begin
            priority if (s_first_point || seen_reg == 2'd0) begin
                push              = 1'b1;
                push_job.do_zero  = 1'b1;
                push_job.zero_end = s_last_point;
                load_newer        = 1'b1;
                seen_next         = s_last_point ? 2'd0 : 2'd1;
            end else if (seen_reg == 2'd1) begin
                if (s_last_point) begin
                    push             = 1'b1;
                    push_job.do_zero = 1'b1;
                    seen_next        = 2'd0;
                end else begin
                    shift_pts = 1'b1;
                    seen_next = 2'd2;
                end
            end else begin
                push             = 1'b1;
                push_job.do_circ = 1'b1;
                push_job.do_zero = s_last_point;
                if (s_last_point) begin
                    seen_next = 2'd0;
                end else begin
                    shift_pts = 1'b1;
                    seen_next = 2'd2;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= 2'd0;
            older_x_reg <= '0;
            older_y_reg <= '0;
            newer_x_reg <= '0;
            newer_y_reg <= '0;
        end else begin
            seen_reg <= seen_next;
            if (shift_pts) begin
                older_x_reg <= newer_x_reg;
                older_y_reg <= newer_y_reg;
            end
            if (shift_pts || load_newer) begin
                newer_x_reg <= s_point_x;
                newer_y_reg <= s_point_y;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/tpc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module tpc_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire tpc_pkg::job_t push_job,
    input  wire logic          pop,
    output tpc_pkg::job_t      pop_job,
    output tpc_pkg::q_status_t q_status
);

    tpc_pkg::job_t                   mem_reg [tpc_pkg::QDEPTH];
    logic [tpc_pkg::QPTR_W-1:0]      wr_reg, rd_reg;
    logic [tpc_pkg::QCNT_W-1:0]      cnt_reg;

    assign pop_job        = mem_reg[rd_reg];
    assign q_status.full  = (cnt_reg == tpc_pkg::QCNT_W'(tpc_pkg::QDEPTH));
    assign q_status.empty = (cnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: src/tpc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module tpc_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tpc_pkg::q_status_t            q_status,
    input  wire tpc_pkg::job_t                 pop_job,
    output logic                               pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [tpc_pkg::RAD_W-1:0]          m_radius,
    output logic                               m_degenerate,
    output logic                               m_path_end
);

    localparam int MAG_W   = tpc_pkg::MAG_W;
    localparam int SQ_W    = tpc_pkg::SQ_W;
    localparam int PROD_W  = tpc_pkg::PROD_W;
    localparam int CROSS_W = tpc_pkg::CROSS_W;
    localparam int ROOT_W  = tpc_pkg::ROOT_W;
    localparam int RAD_W   = tpc_pkg::RAD_W;
    localparam int CNT_W   = tpc_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_CROSS, S_SQRT, S_SAT, S_DIV, S_OUT
    } state_t;

    // multiply sequence: cross terms, squared lengths, length product
    typedef enum logic [3:0] {
        OP_P, OP_Q, OP_WX, OP_WY, OP_UX, OP_UY, OP_VX, OP_VY, OP_ABBC, OP_PROD
    } op_t;

    state_t state_reg;
    op_t    op_reg, op_start;

    logic [MAG_W-1:0]   mag_reg [6];
    logic [5:0]         sgn_reg;
    logic [MAG_W:0]     sm [6];
    logic               zero_pend_reg, zero_end_reg;

    logic [PROD_W-1:0]  mul_a_reg, acc_reg, acc_next, a_sel;
    logic [SQ_W-1:0]    mul_b_reg, b_sel;
    logic [CNT_W-1:0]   cnt_reg, mul_bits;
    logic [2*MAG_W-1:0] p_reg, q_reg, t_reg;
    logic [SQ_W-1:0]    ab_reg, bc_reg, ca_reg, sum_sq;
    logic [CROSS_W-1:0] twoc_reg;

    logic               sp, sq;
    logic [CROSS_W-2:0] cmag;

    logic [2*ROOT_W-1:0] sq_num_reg;
    logic [ROOT_W:0]     rem_reg, rem_next;
    logic [ROOT_W+2:0]   rem_sh, trial;
    logic                rem_ge;
    logic [ROOT_W-1:0]   root_reg, root_next;

    logic [ROOT_W-1:0]   num_reg;
    logic [CROSS_W-1:0]  drem_reg, drem_next;
    logic [CROSS_W:0]    drem_sh;
    logic                div_ge;
    logic [RAD_W-1:0]    quo_reg, quo_next;
    logic                sat;

    logic                m_valid_reg, m_degenerate_reg, m_path_end_reg;
    logic [RAD_W-1:0]    m_radius_reg;

    assign m_valid      = m_valid_reg;
    assign m_radius     = m_radius_reg;
    assign m_degenerate = m_degenerate_reg;
    assign m_path_end   = m_path_end_reg;
    assign pop          = (state_reg == S_IDLE) && !q_status.empty;

    assign sm[0] = tpc_pkg::diff_sm(pop_job.ax, pop_job.bx);
    assign sm[1] = tpc_pkg::diff_sm(pop_job.ay, pop_job.by);
    assign sm[2] = tpc_pkg::diff_sm(pop_job.ax, pop_job.cx);
    assign sm[3] = tpc_pkg::diff_sm(pop_job.ay, pop_job.cy);
    assign sm[4] = tpc_pkg::diff_sm(pop_job.bx, pop_job.cx);
    assign sm[5] = tpc_pkg::diff_sm(pop_job.by, pop_job.cy);

    // shift-add multiplier step
    assign acc_next = mul_b_reg[0] ? acc_reg + mul_a_reg : acc_reg;
    assign sum_sq   = SQ_W'(t_reg) + SQ_W'(acc_next);
    assign op_start = (state_reg == S_IDLE) ? OP_P : op_t'(op_reg + 4'd1);

    always_comb begin
        a_sel    = '0;
        b_sel    = '0;
        mul_bits = CNT_W'(MAG_W);
        unique case (op_start)
            OP_P:    begin a_sel = PROD_W'(mag_reg[0]); b_sel = SQ_W'(mag_reg[3]); end
            OP_Q:    begin a_sel = PROD_W'(mag_reg[1]); b_sel = SQ_W'(mag_reg[2]); end
            OP_WX:   begin a_sel = PROD_W'(mag_reg[4]); b_sel = SQ_W'(mag_reg[4]); end
            OP_WY:   begin a_sel = PROD_W'(mag_reg[5]); b_sel = SQ_W'(mag_reg[5]); end
            OP_UX:   begin a_sel = PROD_W'(mag_reg[0]); b_sel = SQ_W'(mag_reg[0]); end
            OP_UY:   begin a_sel = PROD_W'(mag_reg[1]); b_sel = SQ_W'(mag_reg[1]); end
            OP_VX:   begin a_sel = PROD_W'(mag_reg[2]); b_sel = SQ_W'(mag_reg[2]); end
            OP_VY:   begin a_sel = PROD_W'(mag_reg[3]); b_sel = SQ_W'(mag_reg[3]); end
            OP_ABBC: begin
                a_sel    = PROD_W'(ab_reg);
                b_sel    = bc_reg;
                mul_bits = CNT_W'(SQ_W);
            end
            OP_PROD: begin
                a_sel    = PROD_W'(acc_next[2*SQ_W-1:0]);
                b_sel    = ca_reg;
                mul_bits = CNT_W'(SQ_W);
            end
            default: begin a_sel = '0; b_sel = '0; end
        endcase
    end

    // cross product magnitude from sign-magnitude terms
    always_comb begin
        sp = (sgn_reg[0] ^ sgn_reg[3]) && (p_reg != '0);
        sq = (sgn_reg[1] ^ sgn_reg[2]) && (q_reg != '0);
        if (sp == sq) begin
            cmag = (p_reg >= q_reg) ? (CROSS_W-1)'(p_reg - q_reg)
                                    : (CROSS_W-1)'(q_reg - p_reg);
        end else begin
            cmag = (CROSS_W-1)'(p_reg) + (CROSS_W-1)'(q_reg);
        end
    end

    // restoring square root, one root bit per cycle
    always_comb begin
        rem_sh    = {rem_reg, sq_num_reg[2*ROOT_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        rem_ge    = rem_sh >= trial;
        rem_next  = rem_ge ? (ROOT_W+1)'(rem_sh - trial) : rem_sh[ROOT_W:0];
        root_next = {root_reg[ROOT_W-2:0], rem_ge};
    end

    // restoring division, one quotient bit per cycle
    always_comb begin
        drem_sh   = {drem_reg, num_reg[ROOT_W-1]};
        div_ge    = drem_sh >= {1'b0, twoc_reg};
        drem_next = div_ge ? CROSS_W'(drem_sh - {1'b0, twoc_reg}) : drem_sh[CROSS_W-1:0];
        quo_next  = {quo_reg[RAD_W-2:0], div_ge};
        sat       = {{RAD_W{1'b0}}, root_reg} >= {ROOT_W'(twoc_reg), {RAD_W{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_P;
            m_valid_reg   <= 1'b0;
            zero_pend_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (!q_status.empty) begin
                        zero_pend_reg <= pop_job.do_circ && pop_job.do_zero;
                        zero_end_reg  <= pop_job.zero_end;
                        for (int i = 0; i < 6; i++) begin
                            mag_reg[i] <= sm[i][MAG_W-1:0];
                            sgn_reg[i] <= sm[i][MAG_W];
                        end
                        if (pop_job.do_circ) begin
                            op_reg    <= OP_P;
                            mul_a_reg <= PROD_W'(sm[0][MAG_W-1:0]);
                            mul_b_reg <= SQ_W'(sm[3][MAG_W-1:0]);
                            acc_reg   <= '0;
                            cnt_reg   <= CNT_W'(MAG_W);
                            state_reg <= S_MUL;
                        end else begin
                            m_valid_reg      <= 1'b1;
                            m_radius_reg     <= '0;
                            m_degenerate_reg <= 1'b0;
                            m_path_end_reg   <= pop_job.zero_end;
                            state_reg        <= S_OUT;
                        end
                    end
                end
                S_MUL: begin
                    if (cnt_reg == CNT_W'(1)) begin
                        unique case (op_reg)
                            OP_P:    p_reg  <= acc_next[2*MAG_W-1:0];
                            OP_Q:    q_reg  <= acc_next[2*MAG_W-1:0];
                            OP_WX:   t_reg  <= acc_next[2*MAG_W-1:0];
                            OP_WY:   bc_reg <= sum_sq;
                            OP_UX:   t_reg  <= acc_next[2*MAG_W-1:0];
                            OP_UY:   ab_reg <= sum_sq;
                            OP_VX:   t_reg  <= acc_next[2*MAG_W-1:0];
                            OP_VY:   ca_reg <= sum_sq;
                            OP_ABBC: ;
                            OP_PROD: ;
                            default: ;
                        endcase
                        if (op_reg == OP_Q) begin
                            state_reg <= S_CROSS;
                        end else if (op_reg == OP_PROD) begin
                            sq_num_reg <= (2*ROOT_W)'(acc_next);
                            rem_reg    <= '0;
                            root_reg   <= '0;
                            cnt_reg    <= CNT_W'(ROOT_W);
                            state_reg  <= S_SQRT;
                        end else begin
                            op_reg    <= op_start;
                            mul_a_reg <= a_sel;
                            mul_b_reg <= b_sel;
                            acc_reg   <= '0;
                            cnt_reg   <= mul_bits;
                        end
                    end else begin
                        acc_reg   <= acc_next;
                        mul_a_reg <= {mul_a_reg[PROD_W-2:0], 1'b0};
                        mul_b_reg <= {1'b0, mul_b_reg[SQ_W-1:1]};
                        cnt_reg   <= cnt_reg - 1'b1;
                    end
                end
                S_CROSS: begin
                    if (cmag == '0) begin
                        m_valid_reg      <= 1'b1;
                        m_radius_reg     <= '1;
                        m_degenerate_reg <= 1'b1;
                        m_path_end_reg   <= 1'b0;
                        state_reg        <= S_OUT;
                    end else begin
                        twoc_reg  <= {cmag, 1'b0};
                        op_reg    <= op_start;
                        mul_a_reg <= a_sel;
                        mul_b_reg <= b_sel;
                        acc_reg   <= '0;
                        cnt_reg   <= mul_bits;
                        state_reg <= S_MUL;
                    end
                end
                S_SQRT: begin
                    rem_reg    <= rem_next;
                    root_reg   <= root_next;
                    sq_num_reg <= {sq_num_reg[2*ROOT_W-3:0], 2'b00};
                    cnt_reg    <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= S_SAT;
                    end
                end
                S_SAT: begin
                    if (sat) begin
                        m_valid_reg      <= 1'b1;
                        m_radius_reg     <= '1;
                        m_degenerate_reg <= 1'b0;
                        m_path_end_reg   <= 1'b0;
                        state_reg        <= S_OUT;
                    end else begin
                        num_reg   <= root_reg;
                        drem_reg  <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= CNT_W'(ROOT_W);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    drem_reg <= drem_next;
                    quo_reg  <= quo_next;
                    num_reg  <= {num_reg[ROOT_W-2:0], 1'b0};
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        m_valid_reg      <= 1'b1;
                        m_radius_reg     <= quo_next;
                        m_degenerate_reg <= 1'b0;
                        m_path_end_reg   <= 1'b0;
                        state_reg        <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        if (zero_pend_reg) begin
                            zero_pend_reg    <= 1'b0;
                            m_radius_reg     <= '0;
                            m_degenerate_reg <= 1'b0;
                            m_path_end_reg   <= zero_end_reg;
                        end else begin
                            m_valid_reg <= 1'b0;
                            state_reg   <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: src/three_point_circumradius_stream_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: a point with no radius to compute gets its registered result without any arithmetic;
// an interior point passes through the serial multiplier, root and divider, except that a
// degenerate one stops after the cross product and a saturating one after the root.
// The back end works on one interior point at a time, and gives one more result when it
// also ends the path; a 2-entry job queue lets input transfers continue meanwhile.
// Reset: synchronous active-low aresetn clears path state, queue and output valid.
module three_point_circumradius_stream_top (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [tpc_pkg::COORD_BITS-1:0] s_point_x,
    input  wire logic signed [tpc_pkg::COORD_BITS-1:0] s_point_y,
    input  wire logic                                  s_first_point,
    input  wire logic                                  s_last_point,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [tpc_pkg::RAD_W-1:0]                  m_radius,
    output logic                                       m_degenerate,
    output logic                                       m_path_end
);

    tpc_pkg::q_status_t q_status;
    tpc_pkg::job_t      push_job, pop_job;
    logic               push, pop;

    tpc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_first_point (s_first_point),
        .s_last_point  (s_last_point),
        .q_status      (q_status),
        .push          (push),
        .push_job      (push_job)
    );

    tpc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_status (q_status)
    );

    tpc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_status     (q_status),
        .pop_job      (pop_job),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_radius     (m_radius),
        .m_degenerate (m_degenerate),
        .m_path_end   (m_path_end)
    );

endmodule
`default_nettype wire

FILE: src/tpc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "three_point_circumradius_stream_top_assert.svh"
module tpc_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [tpc_pkg::RAD_W-1:0]    m_radius,
    input wire logic                         m_degenerate,
    input wire logic                         m_path_end
);

    `TPC_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `TPC_ASSERT_IMPL(a_degen_sat, aclk, aresetn, m_valid && m_degenerate, m_radius == '1)
    `TPC_ASSERT_IMPL(a_end_zero, aclk, aresetn, m_valid && m_path_end, m_radius == '0)
    `TPC_ASSERT_IMPL(a_end_ndeg, aclk, aresetn, m_valid && m_path_end, !m_degenerate)

endmodule

bind three_point_circumradius_stream_top tpc_checker u_tpc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_radius     (m_radius),
    .m_degenerate (m_degenerate),
    .m_path_end   (m_path_end)
);
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    localparam int CW         = tpc_pkg::COORD_BITS;
    localparam int RAD_W      = tpc_pkg::RAD_W;
    localparam int CYCLE_CAP  = 3000000;
    localparam int DRAIN_WAIT = 1000;
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 first;
        logic                 last;
        bit                   drain;
    } waypoint_t;

    typedef struct {
        logic [RAD_W-1:0] radius;
        logic             degen;
        logic             path_end;
    } radius_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [CW-1:0] s_point_x = '0;
    logic signed [CW-1:0] s_point_y = '0;
    logic                 s_first_point = 1'b0;
    logic                 s_last_point = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [RAD_W-1:0]     m_radius;
    logic                 m_degenerate;
    logic                 m_path_end;

    waypoint_t waypoints_todo[$];
    radius_t   radii_due[$];
    int        err_count = 0;
    int        results_seen = 0;
    int        cycle_count = 0;

    // path state of the predictor
    longint older_x = 0, older_y = 0, newer_x = 0, newer_y = 0;
    int     held_pts = 0;

    three_point_circumradius_stream_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_point_x(s_point_x), .s_point_y(s_point_y),
        .s_first_point(s_first_point), .s_last_point(s_last_point),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_radius(m_radius), .m_degenerate(m_degenerate), .m_path_end(m_path_end)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [RAD_W-1:0] circumradius(input longint ax, input longint ay,
                                                      input longint bx, input longint by,
                                                      input longint cx, input longint cy,
                                                      output logic degen);
        longint           ux, uy, vx, vy, wx, wy, cr;
        logic [255:0]     twoc, ab, bc, ca, prod, cand, t;
        logic [RAD_W-1:0] r;
        ux = bx - ax; uy = by - ay;
        vx = cx - ax; vy = cy - ay;
        wx = cx - bx; wy = cy - by;
        cr = ux * vy - uy * vx;
        degen = (cr == 0);
        if (degen) begin
            return '1;
        end
        if (cr < 0) begin
            cr = -cr;
        end
        twoc = 256'(cr) << 1;
        ab = 256'(ux * ux + uy * uy);
        bc = 256'(wx * wx + wy * wy);
        ca = 256'(vx * vx + vy * vy);
        prod = ab * bc * ca;
        r = '0;
        for (int b = RAD_W - 1; b >= 0; b--) begin
            cand = 256'(r | (32'd1 << b));
            t = twoc * cand;
            if (t * t <= prod) begin
                r = cand[RAD_W-1:0];
            end
        end
        return r;
    endfunction

    task automatic predict_waypoint(input waypoint_t w);
        radius_t res;
        longint  x, y;
        x = w.x;
        y = w.y;
        if (w.first || held_pts == 0) begin
            res = '{'0, 1'b0, w.last};
            radii_due = {radii_due, res};
            newer_x = x; newer_y = y;
            held_pts = w.last ? 0 : 1;
        end else if (held_pts == 1) begin
            if (w.last) begin
                res = '{'0, 1'b0, 1'b1};
                radii_due = {radii_due, res};
                held_pts = 0;
            end else begin
                older_x = newer_x; older_y = newer_y;
                newer_x = x; newer_y = y;
                held_pts = 2;
            end
        end else begin
            res.radius = circumradius(older_x, older_y, newer_x, newer_y, x, y, res.degen);
            res.path_end = 1'b0;
            radii_due = {radii_due, res};
            if (w.last) begin
                res = '{'0, 1'b0, 1'b1};
                radii_due = {radii_due, res};
                held_pts = 0;
            end else begin
                older_x = newer_x; older_y = newer_y;
                newer_x = x; newer_y = y;
                held_pts = 2;
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        err_count++;
        $display("tb_top: mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic add_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input logic f, input logic l, input bit d = 0);
        waypoint_t w;
        w = '{x, y, f, l, d};
        waypoints_todo = {waypoints_todo, w};
    endtask

    function automatic logic signed [CW-1:0] rand_coord(input int mode);
        case (mode)
            0: return CW'($signed($urandom_range(16)) - 8);
            1: return ($urandom_range(1) != 0) ? C_MAX : C_MIN;
            2: return CW'($signed($urandom_range(4000)) - 2000);
            default: return CW'($urandom);
        endcase
    endfunction

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                waypoint_t acc;
                acc = '{s_point_x, s_point_y, s_first_point, s_last_point, 0};
                predict_waypoint(acc);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (waypoints_todo.size() != 0 &&
                             (!waypoints_todo[0].drain ||
                              (radii_due.size() == 0 && !s_valid))) begin
                    waypoint_t w;
                    w = waypoints_todo.pop_front();
                    s_valid <= 1'b1;
                    s_point_x <= w.x;
                    s_point_y <= w.y;
                    s_first_point <= w.first;
                    s_last_point <= w.last;
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(40, 1);
                        gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(30, 1);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern plus one long hold-off
    int  hold_left = 0;
    bit  hold_done = 0;
    int  stall_mode = 0;
    always @(posedge aclk) begin
        if (cycle_count % 512 == 0) begin
            stall_mode <= $urandom_range(3);
        end
        if (!hold_done && results_seen >= 60) begin
            hold_done <= 1;
            hold_left <= 4000;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(1) != 0);
                2: m_ready <= ($urandom_range(3) == 0);
                default: m_ready <= ((cycle_count / 7) % 2 == 0);
            endcase
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (radii_due.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                radius_t e;
                e = radii_due.pop_front();
                if (m_radius !== e.radius)
                    report_mismatch($sformatf("radius %0d, expected %0d", m_radius, e.radius));
                if (m_degenerate !== e.degen)
                    report_mismatch($sformatf("degenerate %b, expected %b",
                                              m_degenerate, e.degen));
                if (m_path_end !== e.path_end)
                    report_mismatch($sformatf("path_end %b, expected %b",
                                              m_path_end, e.path_end));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        int plen, mode;
        // directed paths
        add_point(5, 7, 1, 1);
        add_point(0, 0, 1, 0); add_point(100, 0, 0, 1);
        add_point(0, 0, 1, 0); add_point(256, 0, 0, 0);
        add_point(256, 256, 0, 0); add_point(0, 256, 0, 1);
        add_point(1, 1, 1, 0); add_point(2, 2, 0, 0); add_point(3, 3, 0, 0);
        add_point(3, 3, 0, 0); add_point(3, 3, 0, 1);
        add_point(C_MIN, C_MIN, 1, 0); add_point(C_MAX, C_MIN, 0, 0);
        add_point(C_MAX, C_MAX, 0, 0); add_point(C_MIN, C_MAX, 0, 1);
        add_point(10, 10, 0, 0); add_point(20, -5, 0, 0);
        add_point(-7, 3, 1, 0); add_point(0, 1, 0, 0); add_point(1, 0, 0, 1, 1);
        add_point(C_MIN, 0, 0, 0); add_point(C_MAX, 1, 0, 0); add_point(0, C_MAX, 0, 1);
        // random: mostly well-formed paths, some noise
        while (waypoints_todo.size() < 970) begin
            if ($urandom_range(9) == 0) begin
                add_point(rand_coord($urandom_range(3)), rand_coord($urandom_range(3)),
                          $urandom_range(4) == 0, $urandom_range(4) == 0);
            end else begin
                plen = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(8, 3);
                mode = $urandom_range(3);
                for (int i = 0; i < plen; i++) begin
                    add_point(rand_coord(($urandom_range(7) == 0) ? 1 : mode),
                              rand_coord(($urandom_range(7) == 0) ? 1 : mode),
                              i == 0, i == plen - 1,
                              waypoints_todo.size() == 500 && i == 0);
                end
            end
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        while (waypoints_todo.size() != 0 || s_valid) @(posedge aclk);
        while (radii_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
